### src/bscp_pkg.sv
// Shared types, offsets and tag tables for the boot sector capacity parser.
package bscp_pkg;

  typedef struct packed {
    logic [7:0] sector_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] disk_blocks;
    logic [1:0]  count_source;
  } out_item_t;

  localparam logic [1:0] SRC_NONE  = 2'd0;
  localparam logic [1:0] SRC_FAT   = 2'd1;
  localparam logic [1:0] SRC_TABLE = 2'd2;

  localparam logic [9:0] SMALL_TOTAL_AT = 10'd19;
  localparam logic [9:0] LARGE_TOTAL_AT = 10'd32;
  localparam logic [9:0] SHORT_TAG_AT   = 10'd54;
  localparam logic [9:0] LONG_TAG_AT    = 10'd82;
  localparam logic [9:0] TABLE_AT       = 10'h1BE;
  localparam logic [9:0] TABLE_END      = 10'h1FE;
  localparam logic [9:0] SIG_AT         = 10'd510;
  localparam logic [9:0] SECTOR_BYTES   = 10'd512;

  localparam logic [7:0]  JMP_SHORT    = 8'hEB;
  localparam logic [7:0]  JMP_NEAR     = 8'hE9;
  localparam logic [7:0]  CALL_NEAR    = 8'hE8;
  localparam logic [7:0]  SIG_LO       = 8'h55;
  localparam logic [7:0]  SIG_HI       = 8'hAA;
  localparam logic [31:0] SMALL_LIMIT  = 32'h0001_0000;

  function automatic logic [7:0] short_tag_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = 8'h46;
      2'd1:    b = 8'h41;
      default: b = 8'h54;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] long_tag_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = 8'h46;
      3'd1:    b = 8'h41;
      3'd2:    b = 8'h54;
      3'd3:    b = 8'h33;
      3'd4:    b = 8'h32;
      default: b = 8'h20;
    endcase
    return b;
  endfunction

endpackage

### src/bscp_scan.sv
// Per-byte field capture, tag match, partition end tracking and result decode.
module bscp_scan
  import bscp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  in_item_t  item,
  output logic      res_load,
  output out_item_t res_item
);

  logic [9:0]  pos_r, pos_nxt;
  logic        jump_r, jump_nxt;
  logic        short_ok_r, short_ok_nxt;
  logic        long_ok_r, long_ok_nxt;
  logic [31:0] large_r, large_nxt;
  logic [15:0] small_r, small_nxt;
  logic [31:0] start_r, start_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] largest_r, largest_nxt;
  logic [7:0]  sig_r, sig_nxt;

  logic        take;
  logic [7:0]  b;
  logic [9:0]  short_off, long_off, tbl_off;
  logic [3:0]  ent_r;
  logic [31:0] end_sum;
  logic        sig_ok;
  logic        fat_rec;

  assign b         = item.sector_byte;
  assign take      = fire && !pos_r[9];
  assign short_off = pos_r - SHORT_TAG_AT;
  assign long_off  = pos_r - LONG_TAG_AT;
  assign tbl_off   = pos_r - TABLE_AT;
  assign ent_r     = tbl_off[3:0];

  always_comb begin
    pos_nxt      = pos_r;
    jump_nxt     = jump_r;
    short_ok_nxt = short_ok_r;
    long_ok_nxt  = long_ok_r;
    large_nxt    = large_r;
    small_nxt    = small_r;
    start_nxt    = start_r;
    len_nxt      = len_r;
    sig_nxt      = sig_r;
    if (take) begin
      pos_nxt = pos_r + 10'd1;
      if (pos_r == 10'd0) begin
        jump_nxt = (b == JMP_SHORT) || (b == JMP_NEAR) || (b == CALL_NEAR);
      end
      if (pos_r == SMALL_TOTAL_AT) begin
        small_nxt[7:0] = b;
      end
      if (pos_r == SMALL_TOTAL_AT + 10'd1) begin
        small_nxt[15:8] = b;
      end
      if (pos_r >= LARGE_TOTAL_AT && pos_r < LARGE_TOTAL_AT + 10'd4) begin
        large_nxt[{pos_r[1:0], 3'b000} +: 8] = b;
      end
      if (pos_r >= SHORT_TAG_AT && pos_r < SHORT_TAG_AT + 10'd3 &&
          b != short_tag_byte(short_off[1:0])) begin
        short_ok_nxt = 1'b0;
      end
      if (pos_r >= LONG_TAG_AT && pos_r < LONG_TAG_AT + 10'd8 &&
          b != long_tag_byte(long_off[2:0])) begin
        long_ok_nxt = 1'b0;
      end
      if (pos_r >= TABLE_AT && pos_r < TABLE_END) begin
        if (ent_r[3:2] == 2'b10) begin
          start_nxt[{ent_r[1:0], 3'b000} +: 8] = b;
        end else if (ent_r[3:2] == 2'b11) begin
          len_nxt[{ent_r[1:0], 3'b000} +: 8] = b;
        end
      end
      if (pos_r == SIG_AT) begin
        sig_nxt = b;
      end
      if (pos_r == SIG_AT + 10'd1) begin
        sig_nxt = {7'd0, (b == SIG_HI) && (sig_r == SIG_LO)};
      end
    end
  end

  assign end_sum = start_r + len_nxt;

  always_comb begin
    largest_nxt = largest_r;
    if (take && pos_r >= TABLE_AT && pos_r < TABLE_END && ent_r == 4'hF &&
        end_sum > largest_r) begin
      largest_nxt = end_sum;
    end
  end

  assign sig_ok  = (pos_nxt >= SECTOR_BYTES) && (sig_nxt == 8'd1);
  assign fat_rec = jump_nxt && (short_ok_nxt || long_ok_nxt);

  always_comb begin
    res_item.disk_blocks  = 32'd0;
    res_item.count_source = SRC_NONE;
    if (sig_ok) begin
      if (fat_rec) begin
        res_item.disk_blocks  = (large_nxt < SMALL_LIMIT) ? {16'd0, small_nxt} : large_nxt;
        res_item.count_source = SRC_FAT;
      end else begin
        res_item.disk_blocks  = largest_nxt;
        res_item.count_source = SRC_TABLE;
      end
    end
  end

  assign res_load = fire && item.last_byte;

  always_ff @(posedge clk) begin
    if (!rst_n || res_load) begin
      pos_r      <= '0;
      jump_r     <= 1'b0;
      short_ok_r <= 1'b1;
      long_ok_r  <= 1'b1;
      large_r    <= '0;
      small_r    <= '0;
      start_r    <= '0;
      len_r      <= '0;
      largest_r  <= '0;
      sig_r      <= '0;
    end else begin
      pos_r      <= pos_nxt;
      jump_r     <= jump_nxt;
      short_ok_r <= short_ok_nxt;
      long_ok_r  <= long_ok_nxt;
      large_r    <= large_nxt;
      small_r    <= small_nxt;
      start_r    <= start_nxt;
      len_r      <= len_nxt;
      largest_r  <= largest_nxt;
      sig_r      <= sig_nxt;
    end
  end

  a_pos_sat: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= SECTOR_BYTES)
    else $error("byte position past sector size");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> (pos_r == 10'd0) && (largest_r == 32'd0) && short_ok_r && long_ok_r)
    else $error("scan state not cleared after last byte");

  a_short_sector: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load && pos_nxt < SECTOR_BYTES) |-> (res_item.count_source == SRC_NONE))
    else $error("short sector reported a count");

  a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load && res_item.count_source == SRC_NONE) |-> (res_item.disk_blocks == 32'd0))
    else $error("nonzero count without signature");

endmodule

### src/bscp_outreg.sv
// Result register with valid/ready hold.
module bscp_outreg
  import bscp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  out_item_t load_item,
  input  logic      out_ready,
  output logic      out_valid,
  output out_item_t out_item
);

  logic      valid_r;
  out_item_t item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= load_item;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_ready) |-> !load)
    else $error("result overwritten before taken");

  a_source_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (item_r.count_source != 2'd3))
    else $error("invalid count source code");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_ready) |=> valid_r && $stable(item_r))
    else $error("pending result changed");

endmodule

### src/boot_sector_capacity_parser_core.sv
// Boot sector capacity parser top level: input register, byte scanner, result register.
// Takes sector 0 one byte per cycle and gives one result per sector, carried by the
// item marked last_byte; that item is held in the input register and its result then
// enters the result register. Throughput is one byte per cycle, set by the single-pass
// scan stage between the input and result registers; the pipe holds only while a result
// sits in the result register untaken, and one further byte is still taken into the input
// register during that hold. Bytes beyond 512 are ignored except for their last mark,
// and missing bytes count as zero, so a short sector reports no signature.
module boot_sector_capacity_parser_core
  import bscp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic      in_v_r;
  in_item_t  in_r;
  logic      adv;
  logic      fire;
  logic      res_load;
  out_item_t res_item;

  assign adv      = !out_valid || out_ready;
  assign fire     = in_v_r && adv;
  assign in_ready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_v_r <= 1'b1;
    end else if (fire) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_item;
    end
  end

  bscp_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .item     (in_r),
    .res_load (res_load),
    .res_item (res_item)
  );

  bscp_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_load),
    .load_item (res_item),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
